FILE: sv/brl_pkg.sv
// Shared types and constants for the Bresenham line raster core.
package brl_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned PitchBits = 13;
  localparam int unsigned AddrBits  = 24;
  localparam int unsigned ColorBits = 32;
  localparam int unsigned DeltaBits = CoordBits;
  localparam int unsigned ErrBits   = CoordBits + 3;

  localparam logic [PitchBits-1:0] RowPitchReset = PitchBits'(640);

  // Request codes carried in req_type
  localparam logic ReqStart = 1'b0;
  localparam logic ReqTick  = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic [CoordBits-1:0] start_x;
    logic [CoordBits-1:0] start_y;
    logic [CoordBits-1:0] end_x;
    logic [CoordBits-1:0] end_y;
    logic [ColorBits-1:0] line_color;
  } in_word_t;

  typedef struct packed {
    logic [CoordBits-1:0] pix_x;
    logic [CoordBits-1:0] pix_y;
    logic [AddrBits-1:0]  pix_addr;
    logic [ColorBits-1:0] pix_color;
    logic                 last_pixel;
  } out_word_t;

  // Walk set up from a pair of endpoints
  typedef struct packed {
    logic                        active;
    logic                        y_major;
    logic                        minor_down;
    logic [CoordBits-1:0]        major_pos;
    logic [CoordBits-1:0]        major_end;
    logic [CoordBits-1:0]        minor_pos;
    logic [DeltaBits-1:0]        delta_major;
    logic [DeltaBits-1:0]        delta_minor;
    logic signed [ErrBits-1:0]   error_term;
  } line_t;

endpackage

FILE: sv/brl_setup.sv
// Endpoint setup: picks the major axis, orders the endpoints and seeds the error term.
module brl_setup (
  input  logic [brl_pkg::CoordBits-1:0] start_x_i,
  input  logic [brl_pkg::CoordBits-1:0] start_y_i,
  input  logic [brl_pkg::CoordBits-1:0] end_x_i,
  input  logic [brl_pkg::CoordBits-1:0] end_y_i,
  output brl_pkg::line_t                line_o
);

  localparam int unsigned CB = brl_pkg::CoordBits;

  logic signed [CB:0]   dx, dy;
  logic [CB:0]          adx, ady;
  logic                 y_major;
  logic                 dx_neg, dy_neg, dx_pos, dy_pos;
  logic                 swap;
  logic [CB-1:0]        dmaj, dmin;

  always_comb begin
    dx     = $signed({1'b0, end_x_i}) - $signed({1'b0, start_x_i});
    dy     = $signed({1'b0, end_y_i}) - $signed({1'b0, start_y_i});
    dx_neg = dx[CB];
    dy_neg = dy[CB];
    dx_pos = !dx_neg && (dx != '0);
    dy_pos = !dy_neg && (dy != '0);
    adx    = dx_neg ? (CB+1)'(-dx) : dx;
    ady    = dy_neg ? (CB+1)'(-dy) : dy;
    y_major = !(ady < adx);
    dmaj   = y_major ? ady[CB-1:0] : adx[CB-1:0];
    dmin   = y_major ? adx[CB-1:0] : ady[CB-1:0];
    swap   = y_major ? dy_neg : dx_neg;

    line_o.y_major     = y_major;
    line_o.delta_major = dmaj;
    line_o.delta_minor = dmin;
    line_o.active      = (dmaj != '0);
    if (y_major) begin
      line_o.major_pos  = swap ? end_y_i : start_y_i;
      line_o.major_end  = swap ? start_y_i : end_y_i;
      line_o.minor_pos  = swap ? end_x_i : start_x_i;
      line_o.minor_down = dy_neg ? dx_pos : dx_neg;
    end else begin
      line_o.major_pos  = swap ? end_x_i : start_x_i;
      line_o.major_end  = swap ? start_x_i : end_x_i;
      line_o.minor_pos  = swap ? end_y_i : start_y_i;
      line_o.minor_down = dx_neg ? dy_pos : dy_neg;
    end
    // 2*dmin - dmaj
    line_o.error_term = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
  end

endmodule

FILE: sv/bresenham_line_raster_core.sv
// Bresenham line raster core: one pixel word per tick on an active line, address y*pitch+x.
// An accepted tick word loads its pixel word straight into the registered output slot.
// Throughput: one word per cycle while the output is not stalled, starts and ticks alike.
// A start word updates the walk state only and never produces a pixel word.
// Reset (rst_ni low, asynchronous): no line active, output empty, row pitch 640.
// The error-term update is registered and feeds back into the next tick.
module bresenham_line_raster_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  brl_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output brl_pkg::out_word_t            out_word_o,
  input  logic                          cfg_we_i,
  input  logic [brl_pkg::PitchBits-1:0] cfg_wdata_i
);

  localparam int unsigned CB = brl_pkg::CoordBits;
  localparam int unsigned EB = brl_pkg::ErrBits;
  localparam int unsigned AB = brl_pkg::AddrBits;
  localparam int unsigned PB = brl_pkg::PitchBits;

  // Configuration
  logic [PB-1:0] row_pitch_q;

  // Walk state
  logic                        busy_q, busy_d;
  logic                        y_major_q, y_major_d;
  logic                        minor_down_q, minor_down_d;
  logic [CB-1:0]               major_pos_q, major_pos_d;
  logic [CB-1:0]               major_end_q, major_end_d;
  logic [CB-1:0]               minor_pos_q, minor_pos_d;
  logic [brl_pkg::DeltaBits-1:0] delta_major_q, delta_major_d;
  logic [brl_pkg::DeltaBits-1:0] delta_minor_q, delta_minor_d;
  logic signed [EB-1:0]        error_term_q, error_term_d;
  logic [brl_pkg::ColorBits-1:0] held_color_q, held_color_d;

  // Output stage
  logic               out_valid_q, out_valid_d;
  brl_pkg::out_word_t out_word_q, out_word_d;

  brl_pkg::line_t setup_line;

  logic                 in_fire, start_fire, tick_fire;
  logic [CB-1:0]        px, py, major_inc;
  logic                 last;
  logic [CB+PB-1:0]     row_base;
  logic signed [EB-1:0] two_min, two_maj;

  brl_setup u_setup (
    .start_x_i (in_word_i.start_x),
    .start_y_i (in_word_i.start_y),
    .end_x_i   (in_word_i.end_x),
    .end_y_i   (in_word_i.end_y),
    .line_o    (setup_line)
  );

  // Take a new word whenever the output slot is free or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign start_fire = in_fire && (in_word_i.req_type == brl_pkg::ReqStart);
  // Ticks while idle are dropped without a pixel word
  assign tick_fire  = in_fire && (in_word_i.req_type == brl_pkg::ReqTick) && busy_q;

  // Current pixel from the walk state
  always_comb begin
    px        = y_major_q ? minor_pos_q : major_pos_q;
    py        = y_major_q ? major_pos_q : minor_pos_q;
    major_inc = major_pos_q + CB'(1);
    last      = (major_inc == major_end_q);
    row_base  = py * row_pitch_q;
    two_min   = $signed({2'b00, delta_minor_q, 1'b0});
    two_maj   = $signed({2'b00, delta_major_q, 1'b0});
  end

  // Next walk state: load on start, advance on tick, otherwise hold
  always_comb begin
    busy_d        = busy_q;
    y_major_d     = y_major_q;
    minor_down_d  = minor_down_q;
    major_pos_d   = major_pos_q;
    major_end_d   = major_end_q;
    minor_pos_d   = minor_pos_q;
    delta_major_d = delta_major_q;
    delta_minor_d = delta_minor_q;
    error_term_d  = error_term_q;
    held_color_d  = held_color_q;
    if (start_fire) begin
      busy_d        = setup_line.active;
      y_major_d     = setup_line.y_major;
      minor_down_d  = setup_line.minor_down;
      major_pos_d   = setup_line.major_pos;
      major_end_d   = setup_line.major_end;
      minor_pos_d   = setup_line.minor_pos;
      delta_major_d = setup_line.delta_major;
      delta_minor_d = setup_line.delta_minor;
      error_term_d  = setup_line.error_term;
      held_color_d  = in_word_i.line_color;
    end else if (tick_fire) begin
      if (error_term_q > 0) begin
        minor_pos_d  = minor_down_q ? minor_pos_q - CB'(1) : minor_pos_q + CB'(1);
        error_term_d = error_term_q + two_min - two_maj;
      end else begin
        error_term_d = error_term_q + two_min;
      end
      major_pos_d = major_inc;
      busy_d      = !last;
    end
  end

  // Output slot: load on tick, drop once taken
  always_comb begin
    out_word_d = out_word_q;
    if (tick_fire) begin
      out_valid_d           = 1'b1;
      out_word_d.pix_x      = px;
      out_word_d.pix_y      = py;
      out_word_d.pix_addr   = AB'(row_base + (CB+PB)'(px));
      out_word_d.pix_color  = held_color_q;
      out_word_d.last_pixel = last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pitch_q   <= brl_pkg::RowPitchReset;
      busy_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      y_major_q     <= 1'b0;
      minor_down_q  <= 1'b0;
      major_pos_q   <= '0;
      major_end_q   <= '0;
      minor_pos_q   <= '0;
      delta_major_q <= '0;
      delta_minor_q <= '0;
      error_term_q  <= '0;
      held_color_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        row_pitch_q <= cfg_wdata_i;
      end
      busy_q        <= busy_d;
      out_valid_q   <= out_valid_d;
      y_major_q     <= y_major_d;
      minor_down_q  <= minor_down_d;
      major_pos_q   <= major_pos_d;
      major_end_q   <= major_end_d;
      minor_pos_q   <= minor_pos_d;
      delta_major_q <= delta_major_d;
      delta_minor_q <= delta_minor_d;
      error_term_q  <= error_term_d;
      held_color_q  <= held_color_d;
    end
  end

  // Pixel payload register, no reset needed
  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_busy_not_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (major_pos_q != major_end_q))
    else $error("active walk sits on its far endpoint");

  a_last_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_fire && last) |=> !busy_q)
    else $error("walk still active after last pixel");

  a_pixel_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(tick_fire))
    else $error("pixel word without an accepted tick");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while pixel word is stalled");

endmodule

FILE: bench/bresenham_line_raster_core_tb.sv
// Self-checking testbench for the Bresenham line raster core with a pixel scoreboard.
module bresenham_line_raster_core_tb;

  localparam int unsigned CB = brl_pkg::CoordBits;
  localparam int unsigned PB = brl_pkg::PitchBits;
  localparam int unsigned CL = brl_pkg::ColorBits;
  localparam int unsigned AB = brl_pkg::AddrBits;
  localparam int unsigned DB = brl_pkg::DeltaBits;
  localparam int unsigned EB = brl_pkg::ErrBits;

  // Scoreboard: walks each line as the core should and queues the pixel words it expects.
  class raster_pixel_checker;
    brl_pkg::line_t     walk;
    logic [PB-1:0]      pitch;
    logic [CL-1:0]      color;
    brl_pkg::out_word_t expected_pixels[$];
    int                 fails;

    function new();
      walk  = '0;
      pitch = brl_pkg::RowPitchReset;
      color = '0;
      fails = 0;
    endfunction

    function void set_pitch(logic [PB-1:0] p);
      pitch = p;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void note_word(brl_pkg::in_word_t w);
      int                 dx, dy, adx, ady, dmin, e;
      logic [CB-1:0]      maj0, maj1, min0, min1, px, py;
      brl_pkg::out_word_t pix;
      if (w.req_type == brl_pkg::ReqStart) begin
        color = w.line_color;
        dx  = int'(w.end_x) - int'(w.start_x);
        dy  = int'(w.end_y) - int'(w.start_y);
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        walk.y_major = !(ady < adx);
        if (!walk.y_major) begin
          if (w.start_x > w.end_x) begin
            maj0 = w.end_x; min0 = w.end_y; maj1 = w.start_x; min1 = w.start_y;
          end else begin
            maj0 = w.start_x; min0 = w.start_y; maj1 = w.end_x; min1 = w.end_y;
          end
        end else begin
          if (w.start_y > w.end_y) begin
            maj0 = w.end_y; min0 = w.end_x; maj1 = w.start_y; min1 = w.start_x;
          end else begin
            maj0 = w.start_y; min0 = w.start_x; maj1 = w.end_y; min1 = w.end_x;
          end
        end
        walk.major_pos   = maj0;
        walk.major_end   = maj1;
        walk.minor_pos   = min0;
        walk.delta_major = maj1 - maj0;
        dmin = int'(min1) - int'(min0);
        walk.minor_down = dmin < 0;
        if (dmin < 0) dmin = -dmin;
        walk.delta_minor = DB'(dmin);
        walk.error_term  = EB'(2 * dmin - int'(walk.delta_major));
        walk.active      = maj0 < maj1;
        return;
      end
      if (!walk.active) return;
      px = walk.y_major ? walk.minor_pos : walk.major_pos;
      py = walk.y_major ? walk.major_pos : walk.minor_pos;
      pix.pix_x      = px;
      pix.pix_y      = py;
      pix.pix_addr   = AB'(32'(py) * 32'(pitch) + 32'(px));
      pix.pix_color  = color;
      pix.last_pixel = CB'(walk.major_pos + 1'b1) == walk.major_end;
      expected_pixels.push_back(pix);
      e = int'($signed(walk.error_term));
      if (e > 0) begin
        walk.minor_pos = walk.minor_down ? walk.minor_pos - 1'b1 : walk.minor_pos + 1'b1;
        e = e - 2 * int'(walk.delta_major);
      end
      e = e + 2 * int'(walk.delta_minor);
      walk.error_term = EB'(e);
      walk.major_pos  = walk.major_pos + 1'b1;
      if (walk.major_pos == walk.major_end) walk.active = 1'b0;
    endfunction

    task report(string what);
      if (fails < 40) $display("mismatch at %0t: %s", $realtime, what);
      fails++;
    endtask

    task check_pixel(brl_pkg::out_word_t got);
      brl_pkg::out_word_t exp;
      if (expected_pixels.size() == 0) begin
        report($sformatf("pixel word (%0d,%0d) with none expected", got.pix_x, got.pix_y));
        return;
      end
      exp = expected_pixels.pop_front();
      if (got.pix_x !== exp.pix_x)
        report($sformatf("pix_x got %h want %h", got.pix_x, exp.pix_x));
      if (got.pix_y !== exp.pix_y)
        report($sformatf("pix_y got %h want %h", got.pix_y, exp.pix_y));
      if (got.pix_addr !== exp.pix_addr)
        report($sformatf("pix_addr got %h want %h", got.pix_addr, exp.pix_addr));
      if (got.pix_color !== exp.pix_color)
        report($sformatf("pix_color got %h want %h", got.pix_color, exp.pix_color));
      if (got.last_pixel !== exp.last_pixel)
        report($sformatf("last_pixel got %b want %b", got.last_pixel, exp.last_pixel));
    endtask
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  brl_pkg::in_word_t  in_word   = '0;
  logic               in_ready;
  logic               out_valid;
  logic               out_ready = 1'b0;
  brl_pkg::out_word_t out_word;
  logic               cfg_we    = 1'b0;
  logic [PB-1:0]      cfg_wdata = '0;

  // Drop all idling in the final phase; calm marks a stretch without sender gaps.
  bit quiet_tail = 1'b0;
  bit calm       = 1'b0;

  raster_pixel_checker sb = new();

  bresenham_line_raster_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Sample both handshakes at the edge; every driven input changes by nonblocking
  // assignment, so the values seen here are the ones the core saw at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_word(in_word);
      if (out_valid && out_ready) sb.check_pixel(out_word);
    end
  end

  // Receiver: hold ready high for a run, then mostly stall for a burst, never in the
  // quiet tail; long runs give stretches with no back-pressure at all.
  initial begin
    repeat (12) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(40, 120)) @(posedge clk);
      else repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  function automatic brl_pkg::in_word_t make_word(logic req, int ax, int ay, int bx, int by,
                                                  logic [CL-1:0] c);
    brl_pkg::in_word_t w;
    w.req_type   = req;
    w.start_x    = CB'(ax);
    w.start_y    = CB'(ay);
    w.end_x      = CB'(bx);
    w.end_y      = CB'(by);
    w.line_color = c;
    return w;
  endfunction

  // Present one word and hold it until the core takes it.
  task automatic send_word(brl_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender idling: an occasional burst of empty cycles, none while calm or in the tail.
  task automatic pace();
    if ($urandom_range(0, 63) == 0) calm = !calm;
    if (!quiet_tail && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Tick words carry random payload; the core must ignore everything but the type.
  task automatic send_ticks(int n);
    for (int i = 0; i < n; i++) begin
      send_word(make_word(brl_pkg::ReqTick, $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom()));
      pace();
    end
  endtask

  task automatic send_line(int ax, int ay, int bx, int by, logic [CL-1:0] c);
    send_word(make_word(brl_pkg::ReqStart, ax, ay, bx, by, c));
    pace();
  endtask

  // Stop sending, wait for every expected pixel word, then let the pipe settle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pitch(logic [PB-1:0] p);
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_pitch(p);
  endtask

  // Random lines: mostly short ones walked to the end, some cut short by a new
  // start, some followed by stray ticks, some long ones, and a little noise.
  // Every word sent counts towards the quota.
  task automatic run_lines(int quota);
    int done, mode, ax, ay, bx, by, d, len, ticks;
    done = 0;
    while (done < quota) begin
      mode = $urandom_range(0, 19);
      ax = $urandom_range(0, 4095);
      ay = $urandom_range(0, 4095);
      if (mode == 19) begin
        send_word(make_word(1'($urandom_range(0, 1)), ax, ay, $urandom_range(0, 4095),
                            $urandom_range(0, 4095), $urandom()));
        done++;
        pace();
        continue;
      end
      if (mode < 15) begin
        d  = $urandom_range(0, 48) - 24;
        bx = ax + d;
        if (bx < 0 || bx > 4095) bx = ax - d;
        d  = $urandom_range(0, 48) - 24;
        by = ay + d;
        if (by < 0 || by > 4095) by = ay - d;
      end else if (mode == 15) begin
        bx = $urandom_range(0, 4095);
        by = ay;
      end else if (mode == 16) begin
        bx = ax;
        by = $urandom_range(0, 1) ? ay : $urandom_range(0, 4095);
      end else begin
        bx = $urandom_range(0, 4095);
        by = $urandom_range(0, 4095);
      end
      len = (bx > ax ? bx - ax : ax - bx);
      if ((by > ay ? by - ay : ay - by) > len) len = (by > ay ? by - ay : ay - by);
      send_line(ax, ay, bx, by, $urandom());
      done++;
      ticks = len;
      case ($urandom_range(0, 9))
        0:       ticks = $urandom_range(0, len);
        1:       ticks = len + $urandom_range(1, 3);
        default: ;
      endcase
      if (ticks > 40) ticks = $urandom_range(1, 40);
      if (ticks > quota - done) ticks = quota - done;
      send_ticks(ticks);
      done += ticks;
    end
  endtask

  initial begin
    logic [PB-1:0] pitches [6];
    pitches[0] = PB'(4096);
    pitches[1] = PB'(1);
    pitches[2] = '0;
    pitches[3] = '1;
    pitches[4] = PB'($urandom_range(1, 4096));
    pitches[5] = PB'($urandom_range(1, 4096));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // Directed part at the reset pitch.
    send_ticks(1);                                   // tick with no line loaded
    send_line(100, 200, 100, 200, 32'hFFFF_FFFF);    // zero length: nothing to draw
    send_ticks(1);
    send_line(10, 20, 14, 18, 32'hA5A5_A5A5);        // x-major, minor steps down
    send_ticks(4);
    send_line(4095, 4095, 4093, 4091, '0);           // y-major, endpoints swapped
    send_ticks(4);
    send_line(0, 4095, 3, 4092, 32'h0000_0001);      // exact diagonal goes y-major
    send_ticks(3);
    send_line(0, 0, 4095, 4095, 32'h8000_0000);      // longest line, cut short
    send_ticks(2);
    send_line(4095, 0, 0, 1, 32'h1234_5678);         // replace it mid-walk
    send_ticks(2);
    send_line(7, 0, 7, 2, 32'h5A5A_5A5A);            // vertical, one stray tick after
    send_ticks(3);

    // Random phases, each at its own pitch; the first also pauses mid-way for a drain.
    for (int p = 0; p < 6; p++) begin
      settle();
      write_pitch(pitches[p]);
      if (p == 5) quiet_tail = 1'b1;
      run_lines(58);
      if (p == 0) settle();
      run_lines(57);
    end

    settle();
    if (sb.fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
